// ===== rtl/core/utf8_to_utf16_name_encoder_defines.svh =====
// Assertion macros used by the checker file.
`ifndef UTF8_TO_UTF16_NAME_ENCODER_DEFINES_SVH
`define UTF8_TO_UTF16_NAME_ENCODER_DEFINES_SVH

// Same-cycle implication, off while reset is held
`define U8U16_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u8u16 check failed");

// Next-cycle implication, off while reset is held
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u8u16 check failed");

`endif

// ===== rtl/core/u8u16_pkg.sv =====
package u8u16_pkg;

    // Status codes of the closing word
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // Most result words one input byte can cause, and the index width
    localparam int MAX_RES   = 3;
    localparam int RES_IDX_W = 2;

    localparam logic [7:0] MAX_UNITS_RESET = 8'd255;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_name;
    } t_in_word;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_status;
        logic [1:0]  status;
        logic [7:0]  unit_count;
        logic        final_res;
    } t_out_word;

    typedef struct packed {
        logic [20:0] code_point_acc;
        logic [1:0]  bytes_pending;
        logic [2:0]  sequence_length;
        logic [7:0]  units_so_far;
        logic [1:0]  error_code;
    } t_enc_state;

    typedef struct packed {
        t_out_word [MAX_RES-1:0] res;
        logic [RES_IDX_W-1:0]    count;
    } t_res_bundle;

endpackage

// ===== rtl/core/u8u16_step.sv =====
module u8u16_step
    import u8u16_pkg::*;
(
    input  t_enc_state  i_state,
    input  t_in_word    i_word,
    input  logic [7:0]  i_max_units,
    output t_enc_state  o_state,
    output t_res_bundle o_bundle
);

    // One byte through the decoder: next state and up to three result words
    always_comb begin
        t_enc_state           s;
        logic                 complete;
        logic [RES_IDX_W-1:0] n;
        logic [20:0]          cp;
        logic [19:0]          v;
        logic                 bad;
        logic [7:0]           b;
        t_out_word [MAX_RES-1:0] res;

        s        = i_state;
        b        = i_word.data_byte;
        complete = 1'b0;
        n        = '0;
        res      = '0;
        cp       = '0;
        v        = '0;
        bad      = 1'b0;

        // lead or continuation byte, only while no error is held
        if (s.error_code == ST_OK) begin
            if (s.bytes_pending == 2'd0) begin
                if (b inside {[8'h00:8'h7F]}) begin
                    s.code_point_acc  = {13'd0, b};
                    s.sequence_length = 3'd1;
                    complete          = 1'b1;
                end else if (b inside {[8'hC2:8'hDF]}) begin
                    s.code_point_acc  = {16'd0, b[4:0]};
                    s.bytes_pending   = 2'd1;
                    s.sequence_length = 3'd2;
                end else if (b inside {[8'hE0:8'hEF]}) begin
                    s.code_point_acc  = {17'd0, b[3:0]};
                    s.bytes_pending   = 2'd2;
                    s.sequence_length = 3'd3;
                end else if (b inside {[8'hF0:8'hF4]}) begin
                    s.code_point_acc  = {18'd0, b[2:0]};
                    s.bytes_pending   = 2'd3;
                    s.sequence_length = 3'd4;
                end else begin
                    s.error_code = ST_INVALID;
                end
            end else begin
                if (b[7:6] != 2'b10) begin
                    s.error_code = ST_INVALID;
                end else begin
                    s.code_point_acc = {s.code_point_acc[14:0], b[5:0]};
                    s.bytes_pending  = s.bytes_pending - 2'd1;
                    complete         = (s.bytes_pending == 2'd0);
                end
            end
        end

        // finished code point: range checks, limit check, emit units
        if (complete) begin
            cp  = s.code_point_acc;
            bad = (s.sequence_length == 3'd3 && cp < 21'h00800) ||
                  (s.sequence_length == 3'd4 && cp < 21'h10000) ||
                  (cp > 21'h10FFFF) ||
                  (cp >= 21'h0D800 && cp <= 21'h0DFFF);
            if (bad) begin
                s.error_code = ST_INVALID;
            end else if (cp <= 21'h0FFFF) begin
                if (s.units_so_far >= i_max_units) begin
                    s.error_code = ST_TOO_LONG;
                end else begin
                    s.units_so_far       = s.units_so_far + 8'd1;
                    res[n].code_unit     = cp[15:0];
                    res[n].unit_count    = s.units_so_far;
                    n                    = n + 2'd1;
                end
            end else begin
                if ({1'b0, s.units_so_far} + 9'd2 > {1'b0, i_max_units}) begin
                    s.error_code = ST_TOO_LONG;
                end else begin
                    v                    = 20'(cp - 21'h10000);
                    s.units_so_far       = s.units_so_far + 8'd1;
                    res[n].code_unit     = 16'hD800 | {6'd0, v[19:10]};
                    res[n].unit_count    = s.units_so_far;
                    n                    = n + 2'd1;
                    s.units_so_far       = s.units_so_far + 8'd1;
                    res[n].code_unit     = 16'hDC00 | {6'd0, v[9:0]};
                    res[n].unit_count    = s.units_so_far;
                    n                    = n + 2'd1;
                end
            end
            s.code_point_acc  = '0;
            s.sequence_length = '0;
        end

        // end of name: closing status word, then clear
        if (i_word.end_of_name) begin
            if (s.error_code == ST_OK && s.bytes_pending != 2'd0) begin
                s.error_code = ST_INVALID;
            end
            res[n].is_status  = 1'b1;
            res[n].status     = s.error_code;
            res[n].unit_count = s.units_so_far;
            n                 = n + 2'd1;
            s                 = '0;
        end

        if (n != '0) begin
            res[n - 2'd1].final_res = 1'b1;
        end

        o_state        = s;
        o_bundle.res   = res;
        o_bundle.count = n;
    end

endmodule

// ===== rtl/core/u8u16_out_buf.sv =====
module u8u16_out_buf
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_res_bundle i_bundle,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_word   o_word
);

    logic                    r_valid;
    logic [RES_IDX_W-1:0]    r_idx;
    t_out_word [MAX_RES-1:0] r_res;
    logic                    drain_last;

    // the word flagged final_res closes the bundle
    assign o_word     = r_res[r_idx];
    assign o_valid    = r_valid;
    assign drain_last = r_valid && i_ready && o_word.final_res;
    assign o_free     = !r_valid || drain_last;

    // bundle register and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load && o_free) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (drain_last) begin
            r_valid <= 1'b0;
        end else if (r_valid && i_ready) begin
            r_idx   <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_bundle.res;
        end
    end

endmodule

// ===== rtl/core/utf8_to_utf16_name_encoder.sv =====
// UTF-8 to UTF-16 name encoder. Takes one UTF-8 byte per word on the input
// channel and returns UTF-16 code units, one per output word, followed by a
// closing status word on the byte flagged end_of_name. A byte is registered,
// decoded in one pass against the running state, and its zero to three
// result words land in a bundle register that drains one word per cycle
// while the output is ready. Throughput is one byte per cycle while each
// byte gives at most one word and the output is ready; a byte that gives
// more (a surrogate pair, or a closing status) holds the input until they
// drain through the single-word output port. Results pass the input and
// then the bundle register. max_units resets to 255; the user must write
// it via i_cfg_we/i_cfg_wdata only while idle; the block does not check.
module utf8_to_utf16_name_encoder
    import u8u16_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word
);

    logic [7:0]  r_max;
    logic        r_in_valid;
    t_in_word    r_in;
    t_enc_state  r_state;
    t_enc_state  n_state;
    t_res_bundle step_bundle;
    logic        buf_free;
    logic        proc_fire;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_UNITS_RESET;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_wdata;
        end
    end

    // input register
    assign proc_fire  = r_in_valid && buf_free;
    assign o_in_ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    // decode pass
    u8u16_step u_step (
        .i_state     (r_state),
        .i_word      (r_in),
        .i_max_units (r_max),
        .o_state     (n_state),
        .o_bundle    (step_bundle)
    );

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (proc_fire) begin
            r_state <= n_state;
        end
    end

    // result bundle and output serialiser
    u8u16_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (proc_fire && (step_bundle.count != '0)),
        .i_bundle (step_bundle),
        .o_free   (buf_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_word   (o_out_word)
    );

endmodule

// ===== rtl/core/u8u16_checker.sv =====
`include "utf8_to_utf16_name_encoder_defines.svh"

module u8u16_checker
    import u8u16_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // a stalled result word keeps o_out_valid high
    `U8U16_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // an empty output side never blocks the input
    `U8U16_ASSERT_NOW(a_idle_ready, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // closing word carries no unit and always ends its byte's results
    `U8U16_ASSERT_NOW(a_status_shape, i_clk, i_rst_n, o_out_valid && o_out_word.is_status,
        o_out_word.code_unit == 16'd0 && o_out_word.final_res)

    // unit words report ok and count at least themselves
    `U8U16_ASSERT_NOW(a_unit_shape, i_clk, i_rst_n, o_out_valid && !o_out_word.is_status,
        o_out_word.status == ST_OK && o_out_word.unit_count != 8'd0)

    // a high surrogate is never the last word of its byte
    `U8U16_ASSERT_NOW(a_pair_order, i_clk, i_rst_n,
        o_out_valid && !o_out_word.is_status && o_out_word.code_unit[15:10] == 6'b110110,
        !o_out_word.final_res)

endmodule

bind utf8_to_utf16_name_encoder u8u16_checker u_u8u16_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ===== bench/utf8_to_utf16_name_encoder_test.sv =====
`timescale 1ns / 100ps

module utf8_to_utf16_name_encoder_test;
    import u8u16_pkg::*;

    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int MAX_REPORTS    = 10;

    // Ways a random name can be spoilt
    typedef enum int {
        FLAW_NONE,
        FLAW_NOISE_BYTE,
        FLAW_CUT_SHORT,
        FLAW_OVERLONG,
        FLAW_SURROGATE,
        FLAW_ABOVE_RANGE,
        FLAW_BAD_CONT
    } t_flaw;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_word  o_out_word;

    // Decoder state mirrored by the predictor
    logic [20:0] acc_point;
    logic [1:0]  cont_left;
    logic [2:0]  seq_len;
    logic [7:0]  units_sent;
    logic [1:0]  name_error;
    logic [7:0]  unit_limit;

    t_out_word   expected_words[$];
    logic [7:0]  name_bytes[$];
    bit          no_gaps;
    int          bytes_sent;
    int          names_sent;
    int          units_seen;
    int          mismatches;
    int          status_tally[3];
    int          idle_cycles;

    utf8_to_utf16_name_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    task automatic clear_name_state();
        acc_point  = '0;
        cont_left  = '0;
        seq_len    = '0;
        units_sent = '0;
        name_error = ST_OK;
    endtask

    function automatic t_out_word make_word(input logic [15:0] unit, input logic flag,
                                            input logic [1:0] stat);
        t_out_word w;
        w.code_unit  = unit;
        w.is_status  = flag;
        w.status     = stat;
        w.unit_count = units_sent;
        w.final_res  = 1'b0;
        return w;
    endfunction

    // Works out the words one accepted byte gives and queues them
    task automatic predict_units(input t_in_word w);
        t_out_word   res[MAX_RES];
        int          n;
        logic        complete;
        logic [20:0] cp;
        logic [20:0] offs;
        n = 0;
        complete = 1'b0;
        if (name_error == ST_OK) begin
            if (cont_left == 2'd0) begin
                if (w.data_byte < 8'h80) begin
                    acc_point = {13'd0, w.data_byte};
                    seq_len = 3'd1;
                    complete = 1'b1;
                end else if (w.data_byte >= 8'hC2 && w.data_byte <= 8'hDF) begin
                    acc_point = {16'd0, w.data_byte[4:0]};
                    cont_left = 2'd1;
                    seq_len = 3'd2;
                end else if (w.data_byte >= 8'hE0 && w.data_byte <= 8'hEF) begin
                    acc_point = {17'd0, w.data_byte[3:0]};
                    cont_left = 2'd2;
                    seq_len = 3'd3;
                end else if (w.data_byte >= 8'hF0 && w.data_byte <= 8'hF4) begin
                    acc_point = {18'd0, w.data_byte[2:0]};
                    cont_left = 2'd3;
                    seq_len = 3'd4;
                end else begin
                    name_error = ST_INVALID;
                end
            end else if (w.data_byte[7:6] != 2'b10) begin
                name_error = ST_INVALID;
            end else begin
                acc_point = {acc_point[14:0], w.data_byte[5:0]};
                cont_left = cont_left - 2'd1;
                complete = (cont_left == 2'd0);
            end
        end

        // Range checks, then one unit or a surrogate pair within the limit
        if (complete) begin
            cp = acc_point;
            if ((seq_len == 3'd3 && cp < 21'h800) || (seq_len == 3'd4 && cp < 21'h10000) ||
                cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
                name_error = ST_INVALID;
            end else if (cp <= 21'hFFFF) begin
                if (units_sent >= unit_limit) begin
                    name_error = ST_TOO_LONG;
                end else begin
                    units_sent = units_sent + 8'd1;
                    res[n] = make_word(cp[15:0], 1'b0, ST_OK);
                    n++;
                end
            end else if ({1'b0, units_sent} + 9'd2 > {1'b0, unit_limit}) begin
                name_error = ST_TOO_LONG;
            end else begin
                offs = cp - 21'h10000;
                units_sent = units_sent + 8'd1;
                res[n] = make_word({6'b110110, offs[19:10]}, 1'b0, ST_OK);
                n++;
                units_sent = units_sent + 8'd1;
                res[n] = make_word({6'b110111, offs[9:0]}, 1'b0, ST_OK);
                n++;
            end
            acc_point = '0;
            seq_len = '0;
        end

        // Closing status word; a sequence left open counts as invalid
        if (w.end_of_name) begin
            if (name_error == ST_OK && cont_left != 2'd0)
                name_error = ST_INVALID;
            res[n] = make_word(16'h0000, 1'b1, name_error);
            n++;
            clear_name_state();
        end

        if (n > 0)
            res[n-1].final_res = 1'b1;
        for (int i = 0; i < n; i++)
            expected_words.push_back(res[i]);
    endtask

    // ---------------------------------------------------------------- driving

    // One byte on the input channel; returns at the edge that takes it
    task automatic send_byte(input logic [7:0] value, input logic eon);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word.data_byte   = value;
        i_in_word.end_of_name = eon;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_units(i_in_word);
        bytes_sent++;
    endtask

    task automatic send_name_bytes();
        for (int i = 0; i < name_bytes.size(); i++)
            send_byte(name_bytes[i], i == name_bytes.size() - 1);
        names_sent++;
    endtask

    // Drop valid and let every expected word come back, plus some slack
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_units(input logic [7:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        unit_limit = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // ---------------------------------------------------------------- name building

    task automatic append_utf8(input logic [20:0] cp, input int len);
        case (len)
            1: name_bytes.push_back({1'b0, cp[6:0]});
            2: begin
                name_bytes.push_back({3'b110, cp[10:6]});
                name_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
                name_bytes.push_back({4'b1110, cp[15:12]});
                name_bytes.push_back({2'b10, cp[11:6]});
                name_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
                name_bytes.push_back({5'b11110, cp[20:18]});
                name_bytes.push_back({2'b10, cp[17:12]});
                name_bytes.push_back({2'b10, cp[11:6]});
                name_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // A legal code point whose shortest form takes len bytes
    function automatic logic [20:0] pick_point(input int len);
        logic [20:0] cp;
        case (len)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3: begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp ^ 21'h2000;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    task automatic append_flaw(input t_flaw flaw);
        int          len;
        logic [20:0] cp;
        logic [7:0]  bad;
        len = $urandom_range(2, 4);
        case (flaw)
            FLAW_NOISE_BYTE: name_bytes.push_back(8'($urandom_range(0, 255)));
            FLAW_CUT_SHORT: begin
                append_utf8(pick_point(len), len);
                repeat ($urandom_range(1, len - 1)) void'(name_bytes.pop_back());
            end
            FLAW_OVERLONG: begin
                // two-byte overlongs show up as C0/C1 leads
                cp = (len == 2) ? 21'($urandom_range(0, 'h7F)) :
                     (len == 3) ? 21'($urandom_range(0, 'h7FF)) :
                                  21'($urandom_range(0, 'hFFFF));
                append_utf8(cp, len);
            end
            FLAW_SURROGATE:   append_utf8(21'($urandom_range('hD800, 'hDFFF)), 3);
            FLAW_ABOVE_RANGE: append_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            FLAW_BAD_CONT: begin
                append_utf8(pick_point(len), len);
                bad = 8'($urandom_range(0, 255));
                if (bad[7:6] == 2'b10)
                    bad[6] = 1'b1;
                name_bytes[name_bytes.size() - $urandom_range(1, len - 1)] = bad;
            end
            default: ;
        endcase
    endtask

    // Mostly clean names; about one in five carries a flaw
    task automatic send_random_name(input int max_chars);
        int    chars;
        int    flaw_at;
        int    len;
        t_flaw flaw;
        name_bytes.delete();
        chars = $urandom_range(1, max_chars);
        flaw = ($urandom_range(0, 99) < 20) ?
               t_flaw'($urandom_range(FLAW_NOISE_BYTE, FLAW_BAD_CONT)) : FLAW_NONE;
        flaw_at = (flaw == FLAW_CUT_SHORT) ? chars : $urandom_range(0, chars);
        for (int i = 0; i <= chars; i++) begin
            if (i == flaw_at)
                append_flaw(flaw);
            if (i < chars) begin
                len = $urandom_range(1, 4);
                append_utf8(pick_point(len), len);
            end
        end
        send_name_bytes();
    endtask

    // ---------------------------------------------------------------- tests

    // Smallest ASCII byte and the largest four-byte character
    task automatic test_valid_extremes();
        name_bytes = '{8'h00, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_name_bytes();
    endtask

    // Bad lead at FF; the byte after it must be ignored
    task automatic test_bad_lead();
        name_bytes = '{8'hFF, 8'h41};
        send_name_bytes();
    endtask

    // Overlong three-byte form, a surrogate, and a point above 10FFFF
    task automatic test_forbidden_points();
        name_bytes = '{8'hE0, 8'h9F, 8'hBF};
        send_name_bytes();
        name_bytes = '{8'hED, 8'hA0, 8'h80};
        send_name_bytes();
        name_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_name_bytes();
    endtask

    // Non-continuation byte mid-sequence, then a name ending mid-sequence
    task automatic test_broken_sequences();
        name_bytes = '{8'hC2, 8'h41};
        send_name_bytes();
        name_bytes = '{8'hE0, 8'hA0};
        send_name_bytes();
    endtask

    task automatic test_too_long();
        write_max_units(8'd1);
        name_bytes = '{8'h41, 8'h42};
        send_name_bytes();
    endtask

    task automatic test_zero_limit();
        write_max_units(8'd0);
        name_bytes = '{8'h7F};
        send_name_bytes();
    endtask

    task automatic test_random_names(input logic [7:0] limit, input int items,
                                     input int max_chars);
        int start;
        write_max_units(limit);
        start = bytes_sent;
        while (bytes_sent - start < items)
            send_random_name(max_chars);
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        test_random_names(8'd255, 30, 6);
        settle();
        no_gaps = 1'b0;
    endtask

    // ---------------------------------------------------------------- result side

    // Output ready: a fresh random stall before each word, none while no_gaps is set
    initial begin : out_side
        int unsigned stall;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
        end
    end

    task automatic note_mismatch(input string what, input t_out_word want,
                                 input t_out_word got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected unit %h status_flag %b status %0d count %0d final %b,",
                     $realtime, what, want.code_unit, want.is_status, want.status,
                     want.unit_count, want.final_res);
        if (mismatches <= MAX_REPORTS)
            $display("    got unit %h status_flag %b status %0d count %0d final %b",
                     got.code_unit, got.is_status, got.status, got.unit_count, got.final_res);
    endtask

    // Each word taken is compared with the oldest one predicted
    always @(posedge i_clk) begin : check_words
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                note_mismatch("word with none expected", '0, o_out_word);
            end else begin
                want = expected_words.pop_front();
                if (o_out_word.code_unit !== want.code_unit ||
                    o_out_word.is_status !== want.is_status ||
                    o_out_word.status !== want.status ||
                    o_out_word.unit_count !== want.unit_count ||
                    o_out_word.final_res !== want.final_res)
                    note_mismatch("word differs", want, o_out_word);
            end
            if (o_out_word.is_status === 1'b1 && o_out_word.status < 2'd3)
                status_tally[o_out_word.status]++;
            else
                units_seen++;
        end
    end

    // Ends the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("utf8_to_utf16_name_encoder_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        no_gaps     = 1'b0;
        bytes_sent  = 0;
        names_sent  = 0;
        units_seen  = 0;
        mismatches  = 0;
        status_tally = '{0, 0, 0};
        clear_name_state();
        unit_limit = MAX_UNITS_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_valid_extremes();
        test_bad_lead();
        test_forbidden_points();
        test_broken_sequences();
        test_too_long();
        test_zero_limit();

        test_random_names(8'd255, 40, 6);
        test_random_names(8'd1, 20, 3);
        test_random_names(8'($urandom_range(2, 6)), 30, 5);
        test_random_names(8'd128, 15, 8);
        test_back_to_back();
        test_random_names(8'($urandom_range(1, 255)), 25, 6);

        settle();
        $display("run: %0d bytes in %0d names, %0d code units; limits 0, 1, small, 128, 255",
                 bytes_sent, names_sent, units_seen);
        $display("closing words: %0d ok, %0d invalid, %0d too long; %0d mismatches",
                 status_tally[ST_OK], status_tally[ST_INVALID], status_tally[ST_TOO_LONG],
                 mismatches);
        if (mismatches == 0)
            $display("utf8_to_utf16_name_encoder_test: clean");
        else
            $display("utf8_to_utf16_name_encoder_test: errors");
        $finish;
    end

endmodule
